/* rtl/avpb_pkg.sv */
`default_nettype none
package avpb_pkg;
	localparam int VideoDepth = 16;
	localparam int AudioLimit = 20;
	localparam int CntW = 5;
	localparam int PtsW = 48;
	localparam int HandleW = 16;

	typedef enum logic [2:0] {
		REQ_PUSH_V = 3'd0,
		REQ_PUSH_A = 3'd1,
		REQ_REND_V = 3'd2,
		REQ_REND_A = 3'd3,
		REQ_REND_B = 3'd4,
		REQ_CLEAR  = 3'd5
	} req_t;

	typedef enum logic [3:0] {
		EV_V_RENDER = 4'd0,
		EV_V_DROP   = 4'd1,
		EV_A_PLAY   = 4'd2,
		EV_A_DROP   = 4'd3,
		EV_V_REFUSE = 4'd4,
		EV_V_FIRST  = 4'd5,
		EV_A_FIRST  = 4'd6,
		EV_NO_AUDIO = 4'd7,
		EV_DONE     = 4'd8
	} ev_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_VFIRST, ST_VPUSH, ST_AFIRST, ST_APUSH, ST_ADROP, ST_VTRIM,
		ST_VREND, ST_AREND, ST_BAUD, ST_BVID, ST_DONE, ST_OUT
	} state_t;

	// entry shared by both queues
	typedef struct packed {
		logic [HandleW-1:0] handle;
		logic [PtsW-1:0]    pts;
	} entry_t;

	// controls issued to a queue chain in one cycle
	typedef struct packed {
		logic   pop;       // shift every cell one step toward the head
		logic   ins;       // insert din (sorted for video, at tail for audio)
		logic   clear;
		entry_t din;
	} qctl_t;
endpackage
`default_nettype wire

/* rtl/avpb_cell.sv */
`default_nettype none
// One queue cell: holds an entry and takes its neighbour's on a shift.
module avpb_cell (
	input  wire logic              clk,
	input  wire logic              load,
	input  wire avpb_pkg::entry_t  din,
	output avpb_pkg::entry_t       dout
);
	avpb_pkg::entry_t ent_q;
	always_ff @(posedge clk) begin
		if (load) ent_q <= din;
	end
	assign dout = ent_q;
endmodule
`default_nettype wire

/* rtl/avpb_vqueue.sv */
`default_nettype none
// Sorted video queue: a row of cells; each cell decides locally whether to
// hold, take the new word, take its left neighbour (insert) or its right
// neighbour (pop).
module avpb_vqueue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire avpb_pkg::qctl_t              ctl,
	output avpb_pkg::entry_t                  head,
	output logic [avpb_pkg::CntW-1:0]         count
);
	localparam int D = avpb_pkg::VideoDepth;
	avpb_pkg::entry_t cell_d [D];
	avpb_pkg::entry_t cell_n [D];
	logic             ld [D];
	logic [D-1:0]     ge;   // cell valid and pts >= new pts (past the head only if tail pts > new pts)
	logic             tail_le;
	logic [avpb_pkg::CntW-1:0] count_q;

	// insert before the first valid cell with pts >= new; no later than the
	// head goes to the head, no earlier than the tail goes after the tail
	always_comb begin
		tail_le = 1'b0;
		for (int i = 0; i < D; i++) begin
			if (i == int'(count_q) - 1) tail_le = (cell_d[i].pts <= ctl.din.pts);
		end
		for (int i = 0; i < D; i++) begin
			ge[i] = (i < int'(count_q)) && (cell_d[i].pts >= ctl.din.pts) &&
				((i == 0) || !tail_le);
		end
		for (int i = 0; i < D; i++) begin
			ld[i] = 1'b0;
			cell_n[i] = ctl.din;
			if (ctl.pop) begin
				ld[i] = 1'b1;
				cell_n[i] = (i < D - 1) ? cell_d[(i < D - 1) ? i + 1 : i] : cell_d[i];
			end else if (ctl.ins) begin
				if (i > 0 && (ge[(i > 0) ? i - 1 : 0] || (|(ge & ((D'(1) << i) - D'(1)))))) begin
					ld[i] = 1'b1;
					cell_n[i] = cell_d[(i > 0) ? i - 1 : 0];
				end else if (ge[i] || i == int'(count_q)) begin
					ld[i] = 1'b1;
					cell_n[i] = ctl.din;
				end
			end
		end
	end

	for (genvar g = 0; g < D; g++) begin : g_cell
		avpb_cell u_cell (.clk(clk), .load(ld[g]), .din(cell_n[g]), .dout(cell_d[g]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (ctl.clear) count_q <= '0;
		else if (ctl.pop) count_q <= count_q - 1'b1;
		else if (ctl.ins) count_q <= count_q + 1'b1;
	end
	assign head = cell_d[0];
	assign count = count_q;
endmodule
`default_nettype wire

/* rtl/avpb_aqueue.sv */
`default_nettype none
// Audio queue in arrival order: append at the tail, shift toward the head.
module avpb_aqueue (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire avpb_pkg::qctl_t              ctl,
	output avpb_pkg::entry_t                  head,
	output logic [avpb_pkg::CntW-1:0]         count
);
	localparam int D = avpb_pkg::AudioLimit;
	avpb_pkg::entry_t cell_d [D];
	avpb_pkg::entry_t cell_n [D];
	logic             ld [D];
	logic [avpb_pkg::CntW-1:0] count_q;

	always_comb begin
		for (int i = 0; i < D; i++) begin
			ld[i] = 1'b0;
			cell_n[i] = ctl.din;
			if (ctl.pop) begin
				ld[i] = 1'b1;
				cell_n[i] = cell_d[(i < D - 1) ? i + 1 : i];
			end else if (ctl.ins && i == int'(count_q)) begin
				ld[i] = 1'b1;
			end
		end
	end

	for (genvar g = 0; g < D; g++) begin : g_cell
		avpb_cell u_cell (.clk(clk), .load(ld[g]), .din(cell_n[g]), .dout(cell_d[g]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (ctl.clear) count_q <= '0;
		else if (ctl.pop) count_q <= count_q - 1'b1;
		else if (ctl.ins) count_q <= count_q + 1'b1;
	end
	assign head = cell_d[0];
	assign count = count_q;
endmodule
`default_nettype wire

/* rtl/av_playout_buffer_top.sv */
`default_nettype none
// Each result word is formed in a walk step, then held in the output state until taken.
// One request at a time: a new one is accepted only in idle, after the done word is taken;
// walk steps that give no word pass straight on to the next step.
// Reset: arst_n clears counts, clock anchor, seen flags and the register;
// queue cells are not cleared and need no clearing pass.
module av_playout_buffer_top (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// tuser: req_type[2:0]
	input  wire logic [2:0]   s_tuser,
	// tdata: frame_handle[15:0], frame_pts[63:16], now_ms[111:64],
	// video_paused[112], audio_paused[113], zero fill to 120
	input  wire logic [119:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// tuser: event_kind[3:0]
	output logic [3:0]        m_tuser,
	// tdata: out_handle[15:0], out_pts[63:16], need_more_audio[64],
	// need_more_video[65], zero fill to 72
	output logic [71:0]       m_tdata,
	output logic              m_tlast,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [1:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	localparam int PW = avpb_pkg::PtsW;

	avpb_pkg::state_t st_q, st_d, st_nx;
	// state to resume after the result word is taken
	avpb_pkg::state_t st_d_ret_q;
	logic              bg_q;
	logic [2:0]        req_q;
	avpb_pkg::entry_t  in_q;
	logic [PW-1:0]     now_q;
	logic              vp_q, ap_q;
	logic [PW-1:0]     anc_t_q, anc_p_q;
	logic              vseen_q, aseen_q;
	logic              adrop_q, rend_q;
	logic [PW-1:0]     dpts_q;
	logic [71:0]       out_q;
	logic [3:0]        ev_q;
	logic              last_q;

	avpb_pkg::qctl_t   vctl, actl;
	avpb_pkg::entry_t  vhead, ahead;
	logic [avpb_pkg::CntW-1:0] vcnt, acnt, vcnt_n, acnt_n;

	// result capture
	logic              emit;
	avpb_pkg::ev_t     ev;
	avpb_pkg::entry_t  ev_ent;
	logic              ev_last;

	logic              anc_set;
	logic [PW-1:0]     anc_t_n, anc_p_n;
	logic [PW+1:0]     due;
	logic              reanchor;

	assign pready = 1'b1;
	assign prdata = {31'd0, bg_q};
	assign s_tready = (st_q == avpb_pkg::ST_IDLE);
	assign m_tvalid = (st_q == avpb_pkg::ST_OUT);
	assign m_tdata = out_q;
	assign m_tuser = ev_q;
	assign m_tlast = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bg_q <= 1'b0;
		else if (psel && penable && pwrite && paddr == 2'd0) bg_q <= pwdata[0];
	end

	always_comb begin
		reanchor = (anc_p_q == '0) || (anc_p_q > vhead.pts);
		anc_t_n = reanchor ? now_q : anc_t_q;
		anc_p_n = reanchor ? vhead.pts : anc_p_q;
		// now - anchor_time + anchor_pts, signed, no wrap
		due = {2'b00, now_q} - {2'b00, anc_t_n} + {2'b00, anc_p_n};
	end

	always_comb begin
		st_d = st_q;
		st_nx = avpb_pkg::ST_IDLE;
		vctl = '{pop: 1'b0, ins: 1'b0, clear: 1'b0, din: in_q};
		actl = '{pop: 1'b0, ins: 1'b0, clear: 1'b0, din: in_q};
		emit = 1'b0;
		ev = avpb_pkg::EV_DONE;
		ev_ent = '0;
		ev_last = 1'b0;
		anc_set = 1'b0;
		vcnt_n = vcnt;
		acnt_n = acnt;
		case (st_q)
			avpb_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					case (s_tuser)
						avpb_pkg::REQ_PUSH_V:
							st_d = vseen_q ? avpb_pkg::ST_VPUSH : avpb_pkg::ST_VFIRST;
						avpb_pkg::REQ_PUSH_A:
							st_d = aseen_q ? avpb_pkg::ST_APUSH : avpb_pkg::ST_AFIRST;
						avpb_pkg::REQ_REND_V: st_d = avpb_pkg::ST_VREND;
						avpb_pkg::REQ_REND_A: st_d = avpb_pkg::ST_AREND;
						avpb_pkg::REQ_REND_B: st_d = avpb_pkg::ST_BAUD;
						default: st_d = avpb_pkg::ST_DONE;
					endcase
				end
			end
			avpb_pkg::ST_VFIRST: begin
				emit = 1'b1; ev = avpb_pkg::EV_V_FIRST; ev_ent = in_q;
				st_nx = avpb_pkg::ST_VPUSH;
			end
			avpb_pkg::ST_VPUSH: begin
				if (int'(vcnt) >= avpb_pkg::VideoDepth) begin
					emit = 1'b1; ev = avpb_pkg::EV_V_REFUSE; ev_ent = in_q;
				end else vctl.ins = 1'b1;
				st_nx = avpb_pkg::ST_DONE;
			end
			avpb_pkg::ST_AFIRST: begin
				emit = 1'b1; ev = avpb_pkg::EV_A_FIRST; ev_ent = in_q;
				st_nx = avpb_pkg::ST_APUSH;
			end
			avpb_pkg::ST_APUSH: begin
				if (int'(acnt) < avpb_pkg::AudioLimit) actl.ins = 1'b1;
				st_nx = avpb_pkg::ST_ADROP;
			end
			avpb_pkg::ST_ADROP: begin
				if (int'(acnt) > avpb_pkg::AudioLimit / 2 &&
					(adrop_q || int'(acnt) >= avpb_pkg::AudioLimit)) begin
					actl.pop = 1'b1; acnt_n = acnt - 1'b1;
					emit = 1'b1; ev = avpb_pkg::EV_A_DROP; ev_ent = ahead;
					st_nx = avpb_pkg::ST_ADROP;
				end else st_nx = adrop_q ? avpb_pkg::ST_VTRIM : avpb_pkg::ST_DONE;
			end
			avpb_pkg::ST_VTRIM: begin
				if (vcnt > 5'd1 && vhead.pts <= dpts_q) begin
					vctl.pop = 1'b1; vcnt_n = vcnt - 1'b1;
					emit = 1'b1; ev = avpb_pkg::EV_V_DROP; ev_ent = vhead;
					st_nx = avpb_pkg::ST_VTRIM;
				end else st_nx = avpb_pkg::ST_DONE;
			end
			avpb_pkg::ST_VREND: begin
				if (vcnt != '0) begin
					anc_set = 1'b1;
					if (due[PW+1] || {2'b00, vhead.pts} > due) st_nx = avpb_pkg::ST_DONE;
					else begin
						vctl.pop = 1'b1; vcnt_n = vcnt - 1'b1;
						emit = 1'b1; ev_ent = vhead;
						ev = (!vp_q && !bg_q && !rend_q) ? avpb_pkg::EV_V_RENDER
							: avpb_pkg::EV_V_DROP;
						st_nx = avpb_pkg::ST_VREND;
					end
				end else st_nx = avpb_pkg::ST_DONE;
			end
			avpb_pkg::ST_AREND: begin
				emit = 1'b1;
				if (acnt != '0) begin
					actl.pop = 1'b1; acnt_n = acnt - 1'b1; ev_ent = ahead;
					ev = ap_q ? avpb_pkg::EV_A_DROP : avpb_pkg::EV_A_PLAY;
				end else ev = avpb_pkg::EV_NO_AUDIO;
				st_nx = avpb_pkg::ST_DONE;
			end
			avpb_pkg::ST_BAUD: begin
				if (acnt != '0) begin
					actl.pop = 1'b1; acnt_n = acnt - 1'b1; ev_ent = ahead; emit = 1'b1;
					ev = ap_q ? avpb_pkg::EV_A_DROP : avpb_pkg::EV_A_PLAY;
				end
				st_nx = avpb_pkg::ST_BVID;
			end
			avpb_pkg::ST_BVID: begin
				if (vcnt != '0) begin
					vctl.pop = 1'b1; vcnt_n = vcnt - 1'b1; ev_ent = vhead; emit = 1'b1;
					ev = (!vp_q && !bg_q) ? avpb_pkg::EV_V_RENDER : avpb_pkg::EV_V_DROP;
				end
				st_nx = avpb_pkg::ST_DONE;
			end
			avpb_pkg::ST_DONE: begin
				emit = 1'b1; ev_last = 1'b1;
				// clear empties both queues as the done word is formed
				if (req_q == avpb_pkg::REQ_CLEAR) begin
					vctl.clear = 1'b1; actl.clear = 1'b1;
					vcnt_n = '0; acnt_n = '0;
				end
				st_nx = avpb_pkg::ST_IDLE;
			end
			avpb_pkg::ST_OUT: begin
				if (m_tready) st_d = last_q ? avpb_pkg::ST_IDLE : st_d_ret_q;
			end
			default: st_d = avpb_pkg::ST_IDLE;
		endcase
		if (st_q != avpb_pkg::ST_IDLE && st_q != avpb_pkg::ST_OUT)
			st_d = emit ? avpb_pkg::ST_OUT : st_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= avpb_pkg::ST_IDLE;
			st_d_ret_q <= avpb_pkg::ST_IDLE;
		end else begin
			st_q <= st_d;
			if (emit) st_d_ret_q <= st_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anc_t_q <= '0; anc_p_q <= '0;
			vseen_q <= 1'b0; aseen_q <= 1'b0;
			adrop_q <= 1'b0; rend_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			if (st_q == avpb_pkg::ST_IDLE && s_tvalid) begin
				adrop_q <= 1'b0; rend_q <= 1'b0;
				if (s_tuser == avpb_pkg::REQ_PUSH_V) vseen_q <= 1'b1;
				if (s_tuser == avpb_pkg::REQ_PUSH_A) aseen_q <= 1'b1;
			end
			if (anc_set) begin anc_t_q <= anc_t_n; anc_p_q <= anc_p_n; end
			if (st_q == avpb_pkg::ST_AREND && acnt != '0) begin
				anc_t_q <= now_q; anc_p_q <= ahead.pts;
			end
			if (emit && st_q == avpb_pkg::ST_ADROP) adrop_q <= 1'b1;
			if (emit && ev == avpb_pkg::EV_V_RENDER) rend_q <= 1'b1;
			if (emit) last_q <= ev_last;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == avpb_pkg::ST_IDLE && s_tvalid) begin
			req_q <= s_tuser;
			in_q.handle <= s_tdata[15:0];
			in_q.pts <= s_tdata[63:16];
			now_q <= s_tdata[111:64];
			vp_q <= s_tdata[112];
			ap_q <= s_tdata[113];
		end
		if (emit) begin
			out_q <= {6'd0,
				(int'(vcnt_n) <= avpb_pkg::AudioLimit / 2),
				(int'(acnt_n) <= avpb_pkg::AudioLimit),
				ev_ent.pts, ev_ent.handle};
			ev_q <= 4'(ev);
		end
		if (emit && st_q == avpb_pkg::ST_ADROP) dpts_q <= ahead.pts;
	end

	avpb_vqueue u_vq (.clk(clk), .arst_n(arst_n), .ctl(vctl), .head(vhead), .count(vcnt));
	avpb_aqueue u_aq (.clk(clk), .arst_n(arst_n), .ctl(actl), .head(ahead), .count(acnt));
endmodule
`default_nettype wire

/* rtl/avpb_checker.sv */
`default_nettype none
module avpb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [3:0]  m_tuser,
	input wire logic [71:0] m_tdata,
	input wire logic        m_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
			$stable(m_tlast))
		else $error("result word changed while stalled");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tuser == 4'(avpb_pkg::EV_DONE))
		else $error("last word is not done");
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("request taken while results pending");
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[63:0] == '0)
		else $error("done word carries a frame");
endmodule
bind av_playout_buffer_top avpb_checker u_chk (.*);
`default_nettype wire

/* sim/tb_av_playout_buffer_top.sv */
`timescale 1ns / 100ps
module tb_av_playout_buffer_top;
	typedef struct packed {
		logic [3:0]  kind;
		logic [15:0] handle;
		logic [47:0] pts;
		logic        need_a;
		logic        need_v;
		logic        last;
	} event_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [2:0] s_tuser = '0;
	logic [119:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [3:0] m_tuser;
	logic [71:0] m_tdata;
	logic m_tlast;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	av_playout_buffer_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// model state
	logic [47:0] vq_pts [avpb_pkg::VideoDepth];
	logic [15:0] vq_hdl [avpb_pkg::VideoDepth];
	int          vq_n;
	logic [47:0] aq_pts [avpb_pkg::AudioLimit];
	logic [15:0] aq_hdl [avpb_pkg::AudioLimit];
	int          aq_n;
	logic [47:0] anchor_time, anchor_pts;
	bit          v_seen, a_seen, bg_mode;

	// request word: {tdata, tuser}
	logic [122:0] pending_words [$];
	event_word_t  expected_events [$];
	int           errors = 0;
	longint       cycle = 0;
	int           hold_off = 0;

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic void post(input logic [3:0] k, input logic [15:0] h,
			input logic [47:0] p, input bit last);
		event_word_t e;
		e.kind = k; e.handle = h; e.pts = p;
		e.need_a = (aq_n <= avpb_pkg::AudioLimit);
		e.need_v = (vq_n <= avpb_pkg::AudioLimit / 2);
		e.last = last;
		expected_events = {expected_events, e};
	endfunction

	function automatic void add_word(input logic [122:0] w);
		pending_words = {pending_words, w};
	endfunction

	function automatic void vpop(output logic [15:0] h, output logic [47:0] p);
		h = vq_hdl[0]; p = vq_pts[0];
		for (int i = 0; i < vq_n - 1; i++) begin
			vq_hdl[i] = vq_hdl[i+1]; vq_pts[i] = vq_pts[i+1];
		end
		vq_n--;
	endfunction

	function automatic void apop(output logic [15:0] h, output logic [47:0] p);
		h = aq_hdl[0]; p = aq_pts[0];
		for (int i = 0; i < aq_n - 1; i++) begin
			aq_hdl[i] = aq_hdl[i+1]; aq_pts[i] = aq_pts[i+1];
		end
		aq_n--;
	endfunction

	function automatic void predict_request(input logic [122:0] w);
		logic [2:0]  req;
		logic [15:0] hd, h;
		logic [47:0] pt, nw, p, drop_pts;
		bit vp, ap, dropped, rendered;
		int pos;
		longint due;
		req = w[2:0]; hd = w[18:3]; pt = w[66:19]; nw = w[114:67];
		vp = w[115]; ap = w[116];
		dropped = 0; rendered = 0; drop_pts = '0;
		case (req)
		avpb_pkg::REQ_PUSH_V: begin
			if (!v_seen) begin
				v_seen = 1; post(avpb_pkg::EV_V_FIRST, hd, pt, 1'b0);
			end
			if (vq_n >= avpb_pkg::VideoDepth) begin
				post(avpb_pkg::EV_V_REFUSE, hd, pt, 1'b0);
			end else begin
				if (vq_n == 0 || vq_pts[0] >= pt) pos = 0;
				else if (vq_pts[vq_n-1] <= pt) pos = vq_n;
				else begin
					pos = 0;
					while (pos < vq_n && vq_pts[pos] < pt) pos++;
				end
				for (int i = vq_n; i > pos; i--) begin
					vq_pts[i] = vq_pts[i-1]; vq_hdl[i] = vq_hdl[i-1];
				end
				vq_pts[pos] = pt; vq_hdl[pos] = hd; vq_n++;
			end
		end
		avpb_pkg::REQ_PUSH_A: begin
			if (!a_seen) begin
				a_seen = 1; post(avpb_pkg::EV_A_FIRST, hd, pt, 1'b0);
			end
			if (aq_n < avpb_pkg::AudioLimit) begin
				aq_pts[aq_n] = pt; aq_hdl[aq_n] = hd; aq_n++;
			end
			if (aq_n >= avpb_pkg::AudioLimit) begin
				while (aq_n > avpb_pkg::AudioLimit / 2) begin
					apop(h, p); dropped = 1; drop_pts = p;
					post(avpb_pkg::EV_A_DROP, h, p, 1'b0);
				end
			end
			if (dropped) begin
				while (vq_n > 1 && vq_pts[0] <= drop_pts) begin
					vpop(h, p); post(avpb_pkg::EV_V_DROP, h, p, 1'b0);
				end
			end
		end
		avpb_pkg::REQ_REND_V: begin
			while (vq_n > 0) begin
				if (anchor_pts == 0 || anchor_pts > vq_pts[0]) begin
					anchor_time = nw; anchor_pts = vq_pts[0];
				end
				due = longint'({16'd0, nw}) - longint'({16'd0, anchor_time})
					+ longint'({16'd0, anchor_pts});
				if (longint'({16'd0, vq_pts[0]}) > due) break;
				vpop(h, p);
				if (!vp && !bg_mode && !rendered) begin
					rendered = 1; post(avpb_pkg::EV_V_RENDER, h, p, 1'b0);
				end else post(avpb_pkg::EV_V_DROP, h, p, 1'b0);
			end
		end
		avpb_pkg::REQ_REND_A: begin
			if (aq_n > 0) begin
				apop(h, p);
				post(ap ? avpb_pkg::EV_A_DROP : avpb_pkg::EV_A_PLAY, h, p, 1'b0);
				anchor_time = nw; anchor_pts = p;
			end else post(avpb_pkg::EV_NO_AUDIO, '0, '0, 1'b0);
		end
		avpb_pkg::REQ_REND_B: begin
			if (aq_n > 0) begin
				apop(h, p); post(ap ? avpb_pkg::EV_A_DROP : avpb_pkg::EV_A_PLAY, h, p, 1'b0);
			end
			if (vq_n > 0) begin
				vpop(h, p);
				post((!vp && !bg_mode) ? avpb_pkg::EV_V_RENDER : avpb_pkg::EV_V_DROP,
					h, p, 1'b0);
			end
		end
		avpb_pkg::REQ_CLEAR: begin
			aq_n = 0; vq_n = 0;
		end
		default: ;
		endcase
		post(avpb_pkg::EV_DONE, '0, '0, 1'b1);
	endfunction

	function automatic logic [122:0] make_word(input logic [2:0] req, input logic [15:0] h,
			input logic [47:0] p, input logic [47:0] nw, input bit vp, input bit ap);
		return {6'b000000, ap, vp, nw, p, h, req};
	endfunction

	// driver: bursts with random gaps
	int gap = 0, burst = 0;
	always @(posedge clk) begin
		cycle++;
		if (s_tvalid && s_tready) begin
			predict_request({s_tdata, s_tuser});
		end
		if (!(s_tvalid && !s_tready)) begin
			if (gap > 0) begin
				gap--;
				s_tvalid <= 1'b0;
			end else if (pending_words.size() > 0 && arst_n) begin
				{s_tdata, s_tuser} <= pending_words[0];
				pending_words.delete(0);
				s_tvalid <= 1'b1;
				if (burst == 0) begin
					burst = $urandom_range(1, 8);
					gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
				end else burst--;
			end else s_tvalid <= 1'b0;
		end
	end

	// receiver stall pattern, plus one long hold-off set by the test
	always @(posedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			m_tready <= 1'b0;
		end else if (cycle % 300 < 100) m_tready <= 1'b1;
		else m_tready <= ($urandom_range(0, 3) != 0);
	end

	// monitor
	always @(posedge clk) begin
		event_word_t e, got;
		if (m_tvalid && m_tready) begin
			got = {m_tuser, m_tdata[15:0], m_tdata[63:16], m_tdata[64],
				m_tdata[65], m_tlast};
			if (expected_events.size() == 0) report("event word with none expected");
			else begin
				e = expected_events[0];
				expected_events.delete(0);
				if (got.kind != e.kind)
					report($sformatf("kind %0d want %0d", got.kind, e.kind));
				if (got.handle != e.handle)
					report($sformatf("handle %h want %h", got.handle, e.handle));
				if (got.pts != e.pts) report($sformatf("pts %h want %h", got.pts, e.pts));
				if (got.need_a != e.need_a) report("need_more_audio");
				if (got.need_v != e.need_v) report("need_more_video");
				if (got.last != e.last) report("tlast");
			end
		end
	end

	always @(posedge clk) begin
		if (cycle > 400000) begin
			$display("[av_playout_buffer_top] ERROR");
			$finish;
		end
	end

	task automatic apb_write(input logic [31:0] v);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= '0; pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		bg_mode = v[0];
	endtask

	task automatic drain();
		while (pending_words.size() > 0 || s_tvalid || expected_events.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [47:0] rnd48();
		return 48'({$urandom(), $urandom()});
	endfunction

	function automatic logic [15:0] rnd16();
		return 16'($urandom());
	endfunction

	function automatic bit rnd1();
		return 1'($urandom());
	endfunction

	task automatic random_phase(input int n);
		logic [47:0] base;
		int r;
		base = 48'($urandom_range(1, 5000));
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				add_word(make_word(3'($urandom_range(0, 7)), rnd16(), rnd48(),
					rnd48(), rnd1(), rnd1()));
			else if (r < 35)
				add_word(make_word(avpb_pkg::REQ_PUSH_V, rnd16(),
					base + 48'($urandom_range(0, 400)), rnd48(), rnd1(), rnd1()));
			else if (r < 65)
				add_word(make_word(avpb_pkg::REQ_PUSH_A, rnd16(),
					base + 48'(20 * i), rnd48(), rnd1(), rnd1()));
			else if (r < 80)
				add_word(make_word(avpb_pkg::REQ_REND_V, rnd16(), rnd48(),
					base + 48'($urandom_range(0, 600)), rnd1(), rnd1()));
			else if (r < 92)
				add_word(make_word(avpb_pkg::REQ_REND_A, rnd16(), rnd48(),
					base + 48'($urandom_range(0, 600)), rnd1(), rnd1()));
			else if (r < 98)
				add_word(make_word(avpb_pkg::REQ_REND_B, rnd16(), rnd48(),
					rnd48(), rnd1(), rnd1()));
			else
				add_word(make_word(avpb_pkg::REQ_CLEAR, rnd16(), rnd48(),
					rnd48(), rnd1(), rnd1()));
		end
	endtask

	initial begin
		vq_n = 0; aq_n = 0; anchor_time = '0; anchor_pts = '0;
		v_seen = 0; a_seen = 0; bg_mode = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		// directed: empty renders, extremes, sort order, fills
		add_word(make_word(avpb_pkg::REQ_REND_A, '0, '0, '0, 1'b0, 1'b0));
		add_word(make_word(avpb_pkg::REQ_REND_B, '0, '0, '0, 1'b0, 1'b0));
		add_word(make_word(avpb_pkg::REQ_REND_V, '0, '0, '1, 1'b0, 1'b0));
		add_word(make_word(avpb_pkg::REQ_PUSH_V, 16'hFFFF, 48'd500, '0, 1'b1, 1'b1));
		add_word(make_word(avpb_pkg::REQ_PUSH_V, 16'h0001, 48'd100, '0, 1'b0, 1'b0));
		add_word(make_word(avpb_pkg::REQ_PUSH_V, 16'h0002, 48'd900, '0, 1'b0, 1'b0));
		add_word(make_word(avpb_pkg::REQ_PUSH_V, 16'h0003, 48'd700, '0, 1'b0, 1'b0));
		add_word(make_word(avpb_pkg::REQ_PUSH_V, 16'h0004, '1, '0, 1'b0, 1'b0));
		add_word(make_word(avpb_pkg::REQ_PUSH_A, 16'h0000, 48'd50, '0, 1'b0, 1'b0));
		add_word(make_word(avpb_pkg::REQ_REND_A, '0, '0, 48'd1000, 1'b0, 1'b1));
		add_word(make_word(avpb_pkg::REQ_REND_V, '0, '0, 48'd1500, 1'b0, 1'b0));
		add_word(make_word(avpb_pkg::REQ_REND_B, '0, '0, '0, 1'b1, 1'b0));
		add_word(make_word(3'd6, '1, '1, '1, 1'b1, 1'b1));
		add_word(make_word(3'd7, '0, '0, '0, 1'b0, 1'b0));
		for (int i = 0; i < 18; i++)
			add_word(make_word(avpb_pkg::REQ_PUSH_V, 16'(i), 48'(2000 - 3 * i), '0,
				1'b0, 1'b0));
		for (int i = 0; i < 21; i++)
			add_word(make_word(avpb_pkg::REQ_PUSH_A, 16'(256 + i), 48'(1990 + i), '0,
				1'b0, 1'b0));
		add_word(make_word(avpb_pkg::REQ_CLEAR, '0, '0, '0, 1'b0, 1'b0));
		drain();
		apb_write(32'd1);
		// long receiver hold-off while the sender keeps offering
		hold_off = 400;
		random_phase(24);
		drain();
		apb_write(32'd0);
		random_phase(16);
		drain();
		apb_write(32'd1);
		random_phase(14);
		drain();
		apb_write(32'd0);
		random_phase(12);
		drain();
		if (errors == 0) $display("[av_playout_buffer_top] OK");
		else $display("[av_playout_buffer_top] ERROR");
		$finish;
	end
endmodule
